FILE: design/mfmaf_pkg.sv
// types, codes and helpers shared by the access filter modules
// no dependencies
`default_nettype none

package mfmaf_pkg;

  localparam int ADDR_W  = 48;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 3;
  localparam int HIDX_W  = 5;

  localparam logic [REQ_W-1:0] REQ_FULL   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SRC    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_CHECKED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  localparam logic REG_IPC = 1'b0;
  localparam logic REG_SPP = 1'b1;

  localparam logic [PROTO_W-1:0] IPC_RESET = 8'd1;
  localparam logic [PROTO_W-1:0] SPP_RESET = 8'd2;
  localparam logic [PROTO_W-1:0] PROTO_ANY = 8'd0;

  typedef struct packed {
    logic [ADDR_W-1:0]  src_value;
    logic [ADDR_W-1:0]  src_care;
    logic [ADDR_W-1:0]  dst_value;
    logic [ADDR_W-1:0]  dst_care;
    logic [PORT_W-1:0]  dport_care;
    logic [PORT_W-1:0]  dport_value;
    logic [PORT_W-1:0]  sport_care;
    logic [PORT_W-1:0]  sport_value;
    logic [PROTO_W-1:0] proto;
    logic               grant;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic chk;
    logic dup;
  } match_t;

  function automatic logic carries_ports(input logic [PROTO_W-1:0] proto,
                                         input logic [PROTO_W-1:0] ipc,
                                         input logic [PROTO_W-1:0] spp);
    return (proto == ipc) || (proto == spp);
  endfunction

endpackage

`default_nettype wire

FILE: design/mfmaf_ram.sv
// generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module mfmaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/mfmaf_match.sv
// shared compare unit: tests one stored rule against the packet or the append key
// depends on mfmaf_pkg
`default_nettype none

module mfmaf_match
  import mfmaf_pkg::*;
(
  input  wire rule_t                entry,
  input  wire rule_t                key,
  input  wire logic [ADDR_W-1:0]    src,
  input  wire logic [ADDR_W-1:0]    dst,
  input  wire logic [PORT_W-1:0]    sport,
  input  wire logic [PORT_W-1:0]    dport,
  input  wire logic [PROTO_W-1:0]   proto,
  input  wire logic                 src_only,
  input  wire logic [PROTO_W-1:0]   ipc_code,
  input  wire logic [PROTO_W-1:0]   spp_code,
  output match_t                    result
);

  logic src_ok;
  logic dst_ok;
  logic port_ok;
  logic proto_ok;

  always_comb begin
    src_ok   = (src & entry.src_care) == entry.src_value;
    dst_ok   = (dst & entry.dst_care) == entry.dst_value;
    port_ok  = ((sport & entry.sport_care) == entry.sport_value) &&
               ((dport & entry.dport_care) == entry.dport_value);
    proto_ok = (entry.proto == PROTO_ANY) ||
               ((proto == entry.proto) &&
                (!carries_ports(entry.proto, ipc_code, spp_code) || port_ok));
    result.chk = src_ok && (src_only || (dst_ok && proto_ok));
    result.dup = (entry == key);
  end

endmodule

`default_nettype wire

FILE: design/masked_first_match_access_filter_core.sv
// first-match access filter: a check or an append walks the rule table one rule
// a cycle through the shared compare unit; the read port of the rule RAM sets the pace
// clear, or a check on an empty table, goes straight to the result; an append that
// stores adds a write step after the walk (on an empty table, no walk); one item at a
// time, and a stalled result holds off the next item
// reset empties the table and restores the protocol codes to 1 and 2; no clearing pass
`default_nettype none

module masked_first_match_access_filter_core
  import mfmaf_pkg::*;
#(
  parameter int RULES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [PROTO_W-1:0]   cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [REQ_W-1:0]     req_type,
  input  wire logic [ADDR_W-1:0]    src_addr,
  input  wire logic [ADDR_W-1:0]    dst_addr,
  input  wire logic [PORT_W-1:0]    src_port,
  input  wire logic [PORT_W-1:0]    dst_port,
  input  wire logic [PROTO_W-1:0]   protocol,
  input  wire logic [ADDR_W-1:0]    src_addr_wildcard,
  input  wire logic [ADDR_W-1:0]    dst_addr_wildcard,
  input  wire logic [PORT_W-1:0]    src_port_wildcard,
  input  wire logic [PORT_W-1:0]    dst_port_wildcard,
  input  wire logic                 grant,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      permit,
  output logic                      hit,
  output logic [HIDX_W-1:0]         hit_index,
  output logic [STAT_W-1:0]         status
);

  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W = $clog2(RULES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RULES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

  state_t              state;
  logic [PROTO_W-1:0]  ipc_code;
  logic [PROTO_W-1:0]  spp_code;
  logic [CNT_W-1:0]    rule_count;
  logic [CNT_W-1:0]    ptr;
  logic [IDX_W-1:0]    cmp_idx;
  logic                data_vld;
  logic [REQ_W-1:0]    req;
  logic [ADDR_W-1:0]   src;
  logic [ADDR_W-1:0]   dst;
  logic [PORT_W-1:0]   sport;
  logic [PORT_W-1:0]   dport;
  logic [PROTO_W-1:0]  proto;
  rule_t               key;
  logic                res_permit;
  logic                res_hit;
  logic [IDX_W-1:0]    res_idx;
  logic [STAT_W-1:0]   res_status;

  rule_t               key_next;
  rule_t               entry;
  match_t              cmp;
  logic                rd_en;
  logic                wr_en;
  logic                is_append;
  logic                last;
  logic [RULE_W-1:0]   rd_data;
  logic [IDX_W+HIDX_W-1:0] idx_wide;

  // normalize an append beat into its stored form
  always_comb begin
    key_next.src_care  = ~src_addr_wildcard;
    key_next.src_value = src_addr & ~src_addr_wildcard;
    key_next.dst_care  = ~dst_addr_wildcard;
    key_next.dst_value = dst_addr & ~dst_addr_wildcard;
    key_next.proto     = protocol;
    key_next.grant     = grant;
    if (carries_ports(protocol, ipc_code, spp_code)) begin
      key_next.sport_care  = ~src_port_wildcard;
      key_next.sport_value = src_port & ~src_port_wildcard;
      key_next.dport_care  = ~dst_port_wildcard;
      key_next.dport_value = dst_port & ~dst_port_wildcard;
    end else begin
      key_next.sport_care  = '0;
      key_next.sport_value = '0;
      key_next.dport_care  = '0;
      key_next.dport_value = '0;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign rd_en     = (state == S_SCAN) && (ptr < rule_count);
  assign wr_en     = (state == S_WRITE);
  assign is_append = (req == REQ_APPEND);
  assign last      = (CNT_W'(cmp_idx) + CNT_ONE) == rule_count;
  assign entry     = rule_t'(rd_data);

  mfmaf_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULES)
  ) u_rules (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rule_count[IDX_W-1:0]),
    .wdata (key),
    .re    (rd_en),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rd_data)
  );

  mfmaf_match u_match (
    .entry    (entry),
    .key      (key),
    .src      (src),
    .dst      (dst),
    .sport    (sport),
    .dport    (dport),
    .proto    (proto),
    .src_only (req == REQ_SRC),
    .ipc_code (ipc_code),
    .spp_code (spp_code),
    .result   (cmp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ipc_code <= IPC_RESET;
      spp_code <= SPP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IPC: ipc_code <= cfg_data;
        REG_SPP: spp_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_count <= '0;
      ptr        <= '0;
      data_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          data_vld <= 1'b0;
          ptr      <= '0;
          if (in_valid) begin
            req        <= req_type;
            src        <= src_addr;
            dst        <= dst_addr;
            sport      <= src_port;
            dport      <= dst_port;
            proto      <= protocol;
            key        <= key_next;
            res_permit <= (req_type == REQ_FULL) && (rule_count == '0);
            res_hit    <= 1'b0;
            res_idx    <= '0;
            res_status <= (req_type == REQ_CLEAR) ? ST_CLEARED : ST_CHECKED;
            case (req_type)
              REQ_CLEAR: begin
                rule_count <= '0;
                state      <= S_DONE;
              end
              REQ_APPEND: begin
                state <= (rule_count == '0) ? S_WRITE : S_SCAN;
              end
              default: begin
                state <= (rule_count == '0) ? S_DONE : S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          data_vld <= rd_en;
          if (rd_en) begin
            ptr     <= ptr + CNT_ONE;
            cmp_idx <= ptr[IDX_W-1:0];
          end
          if (data_vld) begin
            if (is_append) begin
              if (cmp.dup) begin
                res_status <= ST_DUP;
                state      <= S_DONE;
              end else if (last) begin
                if (rule_count == CNT_FULL) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_WRITE;
                end
              end
            end else if (cmp.chk) begin
              res_permit <= entry.grant;
              res_hit    <= 1'b1;
              res_idx    <= cmp_idx;
              state      <= S_DONE;
            end else if (last) begin
              state <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          rule_count <= rule_count + CNT_ONE;
          res_status <= ST_APPENDED;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            permit    <= res_permit;
            hit       <= res_hit;
            hit_index <= idx_wide[HIDX_W-1:0];
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idx_wide = {{HIDX_W{1'b0}}, res_idx};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_FULL)
    else $error("rule count beyond table size");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> rule_count == $past(rule_count) + CNT_ONE)
    else $error("append write did not grow table");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat raised outside done");

  a_compare_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && data_vld) |-> CNT_W'(cmp_idx) < rule_count)
    else $error("compare on unwritten rule");
`endif

endmodule

`default_nettype wire
